[sv/target_track_table_unit_defines.svh]
// assertion macros for the target track table unit
`ifndef TARGET_TRACK_TABLE_UNIT_DEFINES_SVH
`define TARGET_TRACK_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTH
// checked on clk, quiet while rst_n is low
`define TTTU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tttu assertion failed");
// checked on clk, also while rst_n is low
`define TTTU_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tttu reset assertion failed");
`else
`define TTTU_ASSERT(lbl, prop)
`define TTTU_ASSERT_RST(lbl, prop)
`endif
`endif

[sv/tttu_pkg.sv]
// types and constants shared by the target track table unit
`default_nettype none
package tttu_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  localparam logic OP_DETECT = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  localparam logic [1:0] EV_LEADING = 2'd0;
  localparam logic [1:0] EV_FOUND   = 2'd1;
  localparam logic [1:0] EV_LOST    = 2'd2;

  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned CNT_W       = 6;

  localparam logic [31:0] LOST_PERIOD_RST = 32'd1000;

  typedef struct packed {
    logic        [15:0] label;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [31:0] seen;
  } slot_t;

endpackage
`default_nettype wire

[sv/tttu_ram.sv]
// generic simple dual-port ram with registered read
`default_nettype none
module tttu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

[sv/target_track_table_unit.sv]
// target track table: label lookup, allocation and timeout sweep over a slot ram
`default_nettype none
`include "target_track_table_unit_defines.svh"
// Slots live in one ram (label, position, last-seen time) with valid bits in flops,
// and every request walks the ram one slot per cycle. A detection scans the whole
// ram and then loads its result into the output register; it reports leading on a
// label hit, found on allocation of the lowest free slot, and nothing when the
// table is full. A sweep makes one full pass per lost event (each pass finds the
// smallest lost label still left), at most 32 events per sweep. A request that
// yields no result frees the input after its scan. A stalled output register
// holds the unit in its emit state. The input is taken again once the last
// result of a request is in the output register; no clearing pass follows
// reset.
module target_track_table_unit #(
  parameter int MAX_TARGETS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic        [31:0] cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_opcode,
  input  wire logic        [15:0] in_target_label,
  input  wire logic signed [15:0] in_pos_x,
  input  wire logic signed [15:0] in_pos_y,
  input  wire logic        [31:0] in_now_time,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [1:0]  out_event_kind,
  output logic             [15:0] out_label,
  output logic signed      [15:0] out_x,
  output logic signed      [15:0] out_y,
  output logic             [31:0] out_time,
  output logic                    out_last_of_run
);

  localparam int IW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TARGETS - 1);
  localparam int CW = tttu_pkg::CNT_W;

  tttu_pkg::state_t state_r, state_nxt;

  logic        [31:0] period_r, period_nxt;
  logic               op_r, op_nxt;
  logic        [15:0] lbl_r, lbl_nxt;
  logic signed [15:0] x_r, x_nxt;
  logic signed [15:0] y_r, y_nxt;
  logic        [31:0] now_r, now_nxt;

  logic [IW-1:0] scan_idx_r, scan_idx_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic          iss_done_r, iss_done_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic          hit_r, hit_nxt;
  logic          free_r, free_nxt;
  logic          best_r, best_nxt;
  logic          first_r, first_nxt;
  tttu_pkg::slot_t best_slot_r, best_slot_nxt;

  logic [MAX_TARGETS-1:0] valid_r, valid_nxt;
  logic [MAX_TARGETS-1:0] lost_r, lost_nxt;
  logic [MAX_TARGETS-1:0] lost_rest;
  logic [CW-1:0]          n_emit_r, n_emit_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic        [1:0]  out_kind_r, out_kind_nxt;
  logic        [15:0] out_lbl_r, out_lbl_nxt;
  logic signed [15:0] out_x_r, out_x_nxt;
  logic signed [15:0] out_y_r, out_y_nxt;
  logic        [31:0] out_time_r, out_time_nxt;
  logic               out_last_r, out_last_nxt;

  logic              in_accept;
  logic              out_free;
  logic              scan_end;
  logic              has_work;
  logic              sweep_last;
  logic              emit_last;
  logic              iss;
  logic              emit_go;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  tttu_pkg::slot_t   wr_slot;
  tttu_pkg::slot_t   rd_slot;
  logic [$bits(tttu_pkg::slot_t)-1:0] rd_data_w;
  logic [31:0]       age;
  logic              cand;

  tttu_ram #(
    .WIDTH($bits(tttu_pkg::slot_t)),
    .DEPTH(MAX_TARGETS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(wr_slot),
    .rd_en  (iss),
    .rd_addr(scan_idx_r),
    .rd_data(rd_data_w)
  );

  assign rd_slot = rd_data_w;
  assign wr_slot = '{label: lbl_r, x: x_r, y: y_r, seen: now_r};

  // status
  assign in_stall  = (state_r != tttu_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_end  = chk_vld_r && (chk_idx_r == LAST_IDX);
  assign has_work  = (op_r == tttu_pkg::OP_DETECT) ? (hit_r || free_r) : best_r;
  assign age       = now_r - rd_slot.seen;

  always_comb begin
    lost_rest = lost_r;
    lost_rest[best_idx_r] = 1'b0;
  end

  assign sweep_last = (lost_rest == '0) ||
                      (n_emit_r == CW'(tttu_pkg::MAX_RESULTS - 1));
  assign emit_last  = (op_r == tttu_pkg::OP_DETECT) || sweep_last;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tttu_pkg::ST_IDLE: begin
        if (in_accept) state_nxt = tttu_pkg::ST_SCAN;
      end
      tttu_pkg::ST_SCAN: begin
        if (scan_end) state_nxt = tttu_pkg::ST_DECIDE;
      end
      tttu_pkg::ST_DECIDE: begin
        state_nxt = has_work ? tttu_pkg::ST_EMIT : tttu_pkg::ST_IDLE;
      end
      tttu_pkg::ST_EMIT: begin
        if (out_free) state_nxt = emit_last ? tttu_pkg::ST_IDLE : tttu_pkg::ST_SCAN;
      end
      default: state_nxt = tttu_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    iss       = 1'b0;
    emit_go   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = hit_r ? hit_idx_r : free_idx_r;
    case (state_r)
      tttu_pkg::ST_SCAN: begin
        iss = !iss_done_r;
      end
      tttu_pkg::ST_EMIT: begin
        emit_go = out_free;
        ram_we  = out_free && (op_r == tttu_pkg::OP_DETECT);
      end
      default: begin
        iss = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    period_nxt    = period_r;
    op_nxt        = op_r;
    lbl_nxt       = lbl_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    now_nxt       = now_r;
    scan_idx_nxt  = scan_idx_r;
    chk_idx_nxt   = chk_idx_r;
    hit_idx_nxt   = hit_idx_r;
    free_idx_nxt  = free_idx_r;
    best_idx_nxt  = best_idx_r;
    iss_done_nxt  = iss_done_r;
    chk_vld_nxt   = iss;
    hit_nxt       = hit_r;
    free_nxt      = free_r;
    best_nxt      = best_r;
    first_nxt     = first_r;
    best_slot_nxt = best_slot_r;
    valid_nxt     = valid_r;
    lost_nxt      = lost_r;
    n_emit_nxt    = n_emit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_lbl_nxt   = out_lbl_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_time_nxt  = out_time_r;
    out_last_nxt  = out_last_r;
    cand          = 1'b0;

    if (cfg_wr_en) period_nxt = cfg_wr_data;

    if (in_accept) begin
      op_nxt       = in_opcode;
      lbl_nxt      = in_target_label;
      x_nxt        = in_pos_x;
      y_nxt        = in_pos_y;
      now_nxt      = in_now_time;
      first_nxt    = 1'b1;
      n_emit_nxt   = '0;
      scan_idx_nxt = '0;
      iss_done_nxt = 1'b0;
      hit_nxt      = 1'b0;
      free_nxt     = 1'b0;
      best_nxt     = 1'b0;
    end

    if (iss) begin
      chk_idx_nxt = scan_idx_r;
      if (scan_idx_r == LAST_IDX) iss_done_nxt = 1'b1;
      else scan_idx_nxt = scan_idx_r + IW'(1);
    end

    if (chk_vld_r) begin
      if (op_r == tttu_pkg::OP_DETECT) begin
        if (valid_r[chk_idx_r] && (rd_slot.label == lbl_r) && !hit_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = chk_idx_r;
        end
        if (!valid_r[chk_idx_r] && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = chk_idx_r;
        end
      end else begin
        // first pass marks the lost set, later passes only pick from it
        cand = first_r ? (valid_r[chk_idx_r] && (age > period_r)) : lost_r[chk_idx_r];
        if (first_r) lost_nxt[chk_idx_r] = cand;
        if (cand && (!best_r || (rd_slot.label < best_slot_r.label))) begin
          best_nxt      = 1'b1;
          best_idx_nxt  = chk_idx_r;
          best_slot_nxt = rd_slot;
        end
      end
    end

    if (scan_end) first_nxt = 1'b0;

    if (emit_go) begin
      out_valid_nxt = 1'b1;
      if (op_r == tttu_pkg::OP_DETECT) begin
        out_kind_nxt = hit_r ? tttu_pkg::EV_LEADING : tttu_pkg::EV_FOUND;
        out_lbl_nxt  = lbl_r;
        out_x_nxt    = x_r;
        out_y_nxt    = y_r;
        out_time_nxt = now_r;
        out_last_nxt = 1'b1;
        if (!hit_r) valid_nxt[free_idx_r] = 1'b1;
      end else begin
        out_kind_nxt = tttu_pkg::EV_LOST;
        out_lbl_nxt  = best_slot_r.label;
        out_x_nxt    = best_slot_r.x;
        out_y_nxt    = best_slot_r.y;
        out_time_nxt = best_slot_r.seen;
        out_last_nxt = sweep_last;
        valid_nxt[best_idx_r] = 1'b0;
        lost_nxt[best_idx_r]  = 1'b0;
        n_emit_nxt   = n_emit_r + CW'(1);
        scan_idx_nxt = '0;
        iss_done_nxt = 1'b0;
        best_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tttu_pkg::ST_IDLE;
      period_r    <= tttu_pkg::LOST_PERIOD_RST;
      valid_r     <= '0;
      lost_r      <= '0;
      chk_vld_r   <= 1'b0;
      iss_done_r  <= 1'b1;
      out_valid_r <= 1'b0;
      n_emit_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      valid_r     <= valid_nxt;
      lost_r      <= lost_nxt;
      chk_vld_r   <= chk_vld_nxt;
      iss_done_r  <= iss_done_nxt;
      out_valid_r <= out_valid_nxt;
      n_emit_r    <= n_emit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    lbl_r       <= lbl_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    now_r       <= now_nxt;
    scan_idx_r  <= scan_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    hit_r       <= hit_nxt;
    free_r      <= free_nxt;
    best_r      <= best_nxt;
    first_r     <= first_nxt;
    best_slot_r <= best_slot_nxt;
    out_kind_r  <= out_kind_nxt;
    out_lbl_r   <= out_lbl_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_time_r  <= out_time_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_kind_r;
  assign out_label       = out_lbl_r;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_time        = out_time_r;
  assign out_last_of_run = out_last_r;

  `TTTU_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == tttu_pkg::ST_IDLE && !out_valid_r))
  `TTTU_ASSERT(a_lost_in_table, (lost_r & ~valid_r) == '0)
  `TTTU_ASSERT(a_emit_cap, n_emit_r <= CW'(tttu_pkg::MAX_RESULTS))
  `TTTU_ASSERT(a_last_to_idle, (emit_go && emit_last) |=> (state_r == tttu_pkg::ST_IDLE))
  `TTTU_ASSERT(a_hit_valid, (state_r == tttu_pkg::ST_DECIDE && hit_r) |-> valid_r[hit_idx_r])

endmodule
`default_nettype wire
